### hdl/svna_pkg.sv
// Package with types, constants and helpers of the vertex normal accumulator.
`default_nettype none
package svna_pkg;
  localparam int unsigned VERTEX_COUNT = 1024;
  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned NORMAL_BITS = 16;
  localparam int unsigned IDX_BITS = $clog2(VERTEX_COUNT);
  localparam int unsigned SUM_BITS = 56;
  localparam int unsigned DIFF_BITS = COORD_BITS + 1;
  localparam int unsigned MAG_BITS = 31;
  localparam int unsigned SQ_BITS = 2 * MAG_BITS + 2;
  localparam int unsigned ROOT_BITS = SQ_BITS / 2;
  localparam int unsigned NUM_BITS = MAG_BITS + NORMAL_BITS - 1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FACE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic [9:0]                   vertex_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [9:0]                   corner_a;
    logic [9:0]                   corner_b;
    logic [9:0]                   corner_c;
  } in_item_t;

  typedef struct packed {
    logic [9:0]                    out_index;
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    logic                          degenerate;
  } out_item_t;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  // Saturating add of two 56-bit signed values.
  function automatic logic signed [SUM_BITS-1:0] sat_add(
      logic signed [SUM_BITS-1:0] a, logic signed [SUM_BITS-1:0] b);
    logic signed [SUM_BITS:0] s;
    s = {a[SUM_BITS-1], a} + {b[SUM_BITS-1], b};
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      return s[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

### hdl/svna_div.sv
// Restoring divider, one quotient bit per cycle, plus a one-bit-pair square root.
`default_nettype none
module svna_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic                             sqrt_i,
  input  wire logic [svna_pkg::SQ_BITS-1:0]     num_i,
  input  wire logic [svna_pkg::ROOT_BITS-1:0]   den_i,
  output logic                                  done_o,
  output logic [svna_pkg::SQ_BITS-1:0]          res_o
);
  import svna_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(SQ_BITS + 1);

  logic                  busy_q, busy_d, sqrt_q, sqrt_d, done_q, done_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [SQ_BITS-1:0]    num_q, num_d, quo_q, quo_d;
  logic [SQ_BITS+1:0]    rem_q, rem_d;
  logic [ROOT_BITS-1:0]  den_q, den_d;
  logic [SQ_BITS+1:0]    trial, rem_sh;

  always_comb begin
    busy_d = busy_q; sqrt_d = sqrt_q; cnt_d = cnt_q; num_d = num_q;
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; done_d = 1'b0;
    trial = '0; rem_sh = '0;
    if (start_i) begin
      busy_d = 1'b1; sqrt_d = sqrt_i; num_d = num_i; den_d = den_i;
      quo_d = '0; rem_d = '0;
      cnt_d = sqrt_i ? CNT_BITS'(SQ_BITS / 2) : CNT_BITS'(SQ_BITS);
    end else if (busy_q) begin
      if (sqrt_q) begin
        rem_sh = {rem_q[SQ_BITS-1:0], num_q[SQ_BITS-1 -: 2]};
        num_d  = {num_q[SQ_BITS-3:0], 2'b00};
        trial  = {quo_q[SQ_BITS-1:0], 2'b01};
      end else begin
        rem_sh = {rem_q[SQ_BITS:0], num_q[SQ_BITS-1]};
        num_d  = {num_q[SQ_BITS-2:0], 1'b0};
        trial  = (SQ_BITS+2)'(den_q);
      end
      if (rem_sh >= trial) begin
        rem_d = rem_sh - trial;
        quo_d = {quo_q[SQ_BITS-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[SQ_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign res_o  = quo_q;
endmodule
`default_nettype wire

### hdl/smooth_vertex_normal_accumulate.sv
// Top level of the smooth vertex normal accumulator.
// The input channel (in_valid_i, in_stall_o, in_item_i) carries one command per
// transaction: load a vertex position, add a triangle face, or query a normal.
// The output channel (out_valid_o, out_stall_i, out_item_o) carries one result
// transaction for each query and none for loads or faces.
// The block works on one command at a time; in_stall_o is high while busy.
// A load is written in its accept cycle, so the next command can follow at once.
// A face reads the three corner positions (ST_PRD, ST_PWAIT per corner),
// subtracts, forms six products through one shared multiplier, forms the
// cross product, then makes three read-modify-write passes over the sum memories.
// A query reads its sum, shifts the magnitudes right until the largest is below
// 2^31, sums their squares, then takes the square root and three divisions
// in one shared bit-serial divide and root unit.
// A zero sum ends in ST_SHIFT with the degenerate flag set.
// After reset the normal sums are cleared by a sweep over all 1024 vertices,
// one vertex per cycle, during which no command is accepted.
// A result waits in the output register while out_stall_i is high; loads and
// faces are still accepted meanwhile, but a query holds before its sum read
// until the waiting result has been taken.
`default_nettype none
module smooth_vertex_normal_accumulate (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire svna_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output svna_pkg::out_item_t       out_item_o
);
  import svna_pkg::*;

  typedef enum logic [14:0] {
    ST_CLEAR  = 15'b000000000000001,
    ST_IDLE   = 15'b000000000000010,
    ST_PRD    = 15'b000000000000100,
    ST_PWAIT  = 15'b000000000001000,
    ST_DIFF   = 15'b000000000010000,
    ST_MUL    = 15'b000000000100000,
    ST_CROSS  = 15'b000000001000000,
    ST_SRD    = 15'b000000010000000,
    ST_SWAIT  = 15'b000000100000000,
    ST_SWR    = 15'b000001000000000,
    ST_QRD    = 15'b000010000000000,
    ST_QWAIT  = 15'b000100000000000,
    ST_SHIFT  = 15'b001000000000000,
    ST_SQUARE = 15'b010000000000000,
    ST_ARITH  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // Memories: positions and sums, one port each, registered read.
  logic [COORD_BITS-1:0] px_mem [VERTEX_COUNT];
  logic [COORD_BITS-1:0] py_mem [VERTEX_COUNT];
  logic [COORD_BITS-1:0] pz_mem [VERTEX_COUNT];
  logic [SUM_BITS-1:0]   sx_mem [VERTEX_COUNT];
  logic [SUM_BITS-1:0]   sy_mem [VERTEX_COUNT];
  logic [SUM_BITS-1:0]   sz_mem [VERTEX_COUNT];

  logic                  p_we, s_we;
  logic [IDX_BITS-1:0]   p_addr, s_addr;
  logic [COORD_BITS-1:0] p_wx, p_wy, p_wz, p_rx, p_ry, p_rz;
  logic [SUM_BITS-1:0]   s_wx, s_wy, s_wz, s_rx, s_ry, s_rz;

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      px_mem[p_addr] <= p_wx; py_mem[p_addr] <= p_wy; pz_mem[p_addr] <= p_wz;
    end
    p_rx <= px_mem[p_addr]; p_ry <= py_mem[p_addr]; p_rz <= pz_mem[p_addr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      sx_mem[s_addr] <= s_wx; sy_mem[s_addr] <= s_wy; sz_mem[s_addr] <= s_wz;
    end
    s_rx <= sx_mem[s_addr]; s_ry <= sy_mem[s_addr]; s_rz <= sz_mem[s_addr];
  end

  // Command, working registers.
  in_item_t cmd_q, cmd_d;
  logic [IDX_BITS:0] clr_q, clr_d;
  logic [1:0] k_q, k_d;   // corner, component or arithmetic step counter
  logic [2:0] m_q, m_d;   // product counter
  logic signed [COORD_BITS-1:0] va_q [3], vb_q [3], vc_q [3];
  logic signed [COORD_BITS-1:0] va_d [3], vb_d [3], vc_d [3];
  logic signed [DIFF_BITS-1:0] u_q [3], w_q [3], u_d [3], w_d [3];
  logic signed [SUM_BITS-1:0] pr_q [6], pr_d [6];
  logic signed [SUM_BITS-1:0] cr_q [3], cr_d [3];
  logic [SUM_BITS-1:0] mag_q [3], mag_d [3];
  logic neg_q [3], neg_d [3];
  logic [SQ_BITS-1:0] sq_q, sq_d;
  logic [ROOT_BITS-1:0] root_q, root_d;
  logic busy_q, busy_d;
  logic signed [NORMAL_BITS-1:0] nrm_q [3], nrm_d [3];
  logic ov_q, ov_d;
  out_item_t out_q, out_d;

  // Shared multiplier operands (mag x mag unsigned), used for the cross
  // products and for the sum of squares.
  logic [MAG_BITS-1:0] mul_a, mul_b;
  logic [2*MAG_BITS-1:0] mul_p;
  logic mul_neg;
  assign mul_p = mul_a * mul_b;

  logic div_start, div_sqrt, div_done;
  logic [SQ_BITS-1:0] div_num, div_res;

  svna_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .sqrt_i(div_sqrt), .num_i(div_num), .den_i(root_q),
    .done_o(div_done), .res_o(div_res)
  );

  function automatic logic [DIFF_BITS-1:0] dmag(logic signed [DIFF_BITS-1:0] v);
    return v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
  endfunction

  logic [IDX_BITS-1:0] corner;
  logic [SUM_BITS-1:0] mx;
  logic signed [DIFF_BITS-1:0] op1, op2;
  logic [SQ_BITS-1:0] mg, q;
  logic [SUM_BITS-1:0] prodmag;

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; clr_d = clr_q; k_d = k_q; m_d = m_q;
    va_d = va_q; vb_d = vb_q; vc_d = vc_q; u_d = u_q; w_d = w_q;
    pr_d = pr_q; cr_d = cr_q; mag_d = mag_q; neg_d = neg_q; sq_d = sq_q;
    root_d = root_q; busy_d = busy_q; nrm_d = nrm_q; ov_d = ov_q; out_d = out_q;
    p_we = 1'b0; s_we = 1'b0; p_addr = cmd_q.vertex_index[IDX_BITS-1:0];
    s_addr = cmd_q.vertex_index[IDX_BITS-1:0];
    p_wx = cmd_q.pos_x; p_wy = cmd_q.pos_y; p_wz = cmd_q.pos_z;
    s_wx = '0; s_wy = '0; s_wz = '0;
    div_start = 1'b0; div_sqrt = 1'b0; div_num = '0;
    mul_a = '0; mul_b = '0; mul_neg = 1'b0; op1 = '0; op2 = '0;
    mx = '0; mg = '0; q = '0; prodmag = '0;
    unique case (k_q)
      2'd0: corner = cmd_q.corner_a[IDX_BITS-1:0];
      2'd1: corner = cmd_q.corner_b[IDX_BITS-1:0];
      default: corner = cmd_q.corner_c[IDX_BITS-1:0];
    endcase

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        s_we = 1'b1; s_addr = clr_q[IDX_BITS-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (IDX_BITS+1)'(VERTEX_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_item_i; k_d = '0; m_d = '0;
          unique case (opcode_e'(in_item_i.opcode))
            OP_LOAD: begin
              p_we = 1'b1; s_we = 1'b1;
              p_addr = in_item_i.vertex_index[IDX_BITS-1:0];
              s_addr = in_item_i.vertex_index[IDX_BITS-1:0];
              p_wx = in_item_i.pos_x; p_wy = in_item_i.pos_y; p_wz = in_item_i.pos_z;
            end
            OP_FACE:  state_d = ST_PRD;
            OP_QUERY: state_d = ST_QRD;
            default: ;
          endcase
        end
      end
      ST_PRD: begin
        p_addr = corner; state_d = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (k_q == 2'd0) begin
          va_d[0] = p_rx; va_d[1] = p_ry; va_d[2] = p_rz;
        end else if (k_q == 2'd1) begin
          vb_d[0] = p_rx; vb_d[1] = p_ry; vb_d[2] = p_rz;
        end else begin
          vc_d[0] = p_rx; vc_d[1] = p_ry; vc_d[2] = p_rz;
        end
        if (k_q == 2'd2) begin
          k_d = '0; state_d = ST_DIFF;
        end else begin
          k_d = k_q + 2'd1; state_d = ST_PRD;
        end
      end
      ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          u_d[i] = DIFF_BITS'(vc_q[i]) - DIFF_BITS'(vb_q[i]);
          w_d[i] = DIFF_BITS'(vb_q[i]) - DIFF_BITS'(va_q[i]);
        end
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // Products in order: uy*wz, uz*wy, uz*wx, ux*wz, ux*wy, uy*wx.
        unique case (m_q)
          3'd0: begin op1 = u_q[1]; op2 = w_q[2]; end
          3'd1: begin op1 = u_q[2]; op2 = w_q[1]; end
          3'd2: begin op1 = u_q[2]; op2 = w_q[0]; end
          3'd3: begin op1 = u_q[0]; op2 = w_q[2]; end
          3'd4: begin op1 = u_q[0]; op2 = w_q[1]; end
          default: begin op1 = u_q[1]; op2 = w_q[0]; end
        endcase
        mul_a = MAG_BITS'(dmag(op1)); mul_b = MAG_BITS'(dmag(op2));
        mul_neg = op1[DIFF_BITS-1] ^ op2[DIFF_BITS-1];
        prodmag = (mul_p > (2*MAG_BITS)'(SUM_MAX)) ? SUM_MAX
                  : SUM_BITS'(mul_p);
        pr_d[m_q] = mul_neg ? SUM_BITS'(-prodmag) : SUM_BITS'(prodmag);
        if (m_q == 3'd5) begin
          m_d = '0; state_d = ST_CROSS;
        end else begin
          m_d = m_q + 3'd1;
        end
      end
      ST_CROSS: begin
        cr_d[0] = sat_add(pr_q[0], -pr_q[1]);
        cr_d[1] = sat_add(pr_q[2], -pr_q[3]);
        cr_d[2] = sat_add(pr_q[4], -pr_q[5]);
        // Negating SUM_MIN wraps; handle it by saturating explicitly.
        if (pr_q[1] == SUM_MIN) cr_d[0] = pr_q[0][SUM_BITS-1] ? sat_add(pr_q[0] + 1'b1,
                                 SUM_MAX) : SUM_MAX;
        if (pr_q[3] == SUM_MIN) cr_d[1] = pr_q[2][SUM_BITS-1] ? sat_add(pr_q[2] + 1'b1,
                                 SUM_MAX) : SUM_MAX;
        if (pr_q[5] == SUM_MIN) cr_d[2] = pr_q[4][SUM_BITS-1] ? sat_add(pr_q[4] + 1'b1,
                                 SUM_MAX) : SUM_MAX;
        k_d = '0; state_d = ST_SRD;
      end
      ST_SRD: begin
        s_addr = corner; state_d = ST_SWAIT;
      end
      ST_SWAIT: begin
        s_addr = corner; state_d = ST_SWR;
      end
      ST_SWR: begin
        s_addr = corner; s_we = 1'b1;
        s_wx = sat_add(s_rx, cr_q[0]);
        s_wy = sat_add(s_ry, cr_q[1]);
        s_wz = sat_add(s_rz, cr_q[2]);
        if (k_q == 2'd2) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 2'd1; state_d = ST_SRD;
        end
      end
      ST_QRD: begin
        // Hold here while an earlier result still waits in the output register.
        if (!ov_q || !out_stall_i) begin
          state_d = ST_QWAIT;
        end
      end
      ST_QWAIT: begin
        neg_d[0] = s_rx[SUM_BITS-1]; neg_d[1] = s_ry[SUM_BITS-1];
        neg_d[2] = s_rz[SUM_BITS-1];
        mag_d[0] = s_rx[SUM_BITS-1] ? SUM_BITS'(-s_rx) : s_rx;
        mag_d[1] = s_ry[SUM_BITS-1] ? SUM_BITS'(-s_ry) : s_ry;
        mag_d[2] = s_rz[SUM_BITS-1] ? SUM_BITS'(-s_rz) : s_rz;
        k_d = '0; state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        // One right shift per cycle until the largest magnitude is below 2^31.
        mx = mag_q[0];
        if (mag_q[1] > mx) mx = mag_q[1];
        if (mag_q[2] > mx) mx = mag_q[2];
        if (mx == '0) begin
          out_d = '0; out_d.out_index = cmd_q.vertex_index; out_d.degenerate = 1'b1;
          ov_d = 1'b1; state_d = ST_IDLE;
        end else if (mx[SUM_BITS-1:MAG_BITS] != '0) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else begin
          sq_d = '0; state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        // Sum of squares, one component a cycle through the shared multiplier.
        mul_a = mag_q[k_q][MAG_BITS-1:0]; mul_b = mag_q[k_q][MAG_BITS-1:0];
        sq_d = sq_q + SQ_BITS'(mul_p);
        if (k_q == 2'd2) begin
          k_d = '0; busy_d = 1'b0; state_d = ST_ARITH;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_ARITH: begin
        // Step 0 is the root; steps 1..3 are the three divisions.
        if (!busy_q) begin
          busy_d = 1'b1; div_start = 1'b1;
          if (k_q == 2'd0) begin
            div_sqrt = 1'b1; div_num = sq_q;
          end else begin
            mg = SQ_BITS'(mag_q[k_q - 2'd1]);
            div_num = SQ_BITS'(mg[MAG_BITS-1:0]) << (NORMAL_BITS - 1);
          end
        end else if (div_done) begin
          busy_d = 1'b0;
          if (k_q == 2'd0) begin
            root_d = div_res[ROOT_BITS-1:0]; k_d = 2'd1;
          end else begin
            q = div_res;
            if (neg_q[k_q - 2'd1]) begin
              nrm_d[k_q - 2'd1] = (q >= SQ_BITS'(1 << (NORMAL_BITS - 1)))
                  ? {1'b1, {(NORMAL_BITS-1){1'b0}}} : NORMAL_BITS'(-q);
            end else begin
              nrm_d[k_q - 2'd1] = (q >= SQ_BITS'(1 << (NORMAL_BITS - 1)))
                  ? {1'b0, {(NORMAL_BITS-1){1'b1}}} : NORMAL_BITS'(q);
            end
            if (k_q == 2'd3) begin
              out_d.out_index = cmd_q.vertex_index;
              out_d.normal_x = nrm_q[0]; out_d.normal_y = nrm_q[1];
              out_d.normal_z = nrm_d[2]; out_d.degenerate = 1'b0;
              ov_d = 1'b1; state_d = ST_IDLE;
            end else begin
              k_d = k_q + 2'd1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; ov_q <= 1'b0; busy_q <= 1'b0;
      k_q <= '0; m_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; ov_q <= ov_d; busy_q <= busy_d;
      k_q <= k_d; m_q <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; va_q <= va_d; vb_q <= vb_d; vc_q <= vc_d; u_q <= u_d;
    w_q <= w_d; pr_q <= pr_d; cr_q <= cr_d; mag_q <= mag_d; neg_q <= neg_d;
    sq_q <= sq_d; root_q <= root_d; nrm_q <= nrm_d; out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;
endmodule
`default_nettype wire
